// ----- rtl/rpa_pkg.sv -----
// Shared types and codes for the reference-counted page allocator.
`timescale 1ns / 1ps

package rpa_pkg;

  localparam int OP_W     = 2;
  localparam int PAGE_W   = 15;
  localparam int STATUS_W = 2;
  localparam int OCNT_W   = 8;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_ADDREF = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic clear_en;  // write zero into the count memory at the sweep index
    logic load;      // input transfer: latch op/page, start memory reads
    logic fire;      // execute: update memories, load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;  // sweep is on its last entry
    logic out_busy;    // result register holds a result that is not taken
  } sts_t;

endpackage

// ----- rtl/rpa_ctrl.sv -----
// Controller state machine: reset sweep, accept, execute.
`timescale 1ns / 1ps

module rpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  rpa_pkg::sts_t sts,
  output rpa_pkg::cmd_t cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next   = state;
    cmd.clear_en = 1'b0;
    cmd.load     = 1'b0;
    cmd.fire     = 1'b0;
    s_tready     = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register can take the new result
        if (!sts.out_busy) begin
          cmd.fire   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/rpa_dp.sv -----
// Datapath: free stack, count memory, depth tracking and result register.
`timescale 1ns / 1ps

module rpa_dp #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rpa_pkg::cmd_t                     cmd,
  output rpa_pkg::sts_t                     sts,
  input  logic [rpa_pkg::OP_W-1:0]          in_op,
  input  logic [rpa_pkg::PAGE_W-1:0]        in_page,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rpa_pkg::STATUS_W-1:0]      out_status,
  output logic [rpa_pkg::PAGE_W-1:0]        out_page,
  output logic [rpa_pkg::OCNT_W-1:0]        out_count,
  output logic                              out_released
);

  localparam int IDX_W   = $clog2(NUM_PAGES);
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam int PX_W    = (IDX_W > rpa_pkg::PAGE_W) ? IDX_W : rpa_pkg::PAGE_W;
  localparam int CX_W    = (COUNT_BITS > rpa_pkg::OCNT_W) ? COUNT_BITS : rpa_pkg::OCNT_W;
  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(NUM_PAGES);
  localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(NUM_PAGES - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic [IDX_W-1:0]      stack_mem [NUM_PAGES];
  logic [COUNT_BITS-1:0] cnt_mem   [NUM_PAGES];

  logic [rpa_pkg::OP_W-1:0]   op_q;
  logic [rpa_pkg::PAGE_W-1:0] page_q;
  logic [IDX_W-1:0]           stack_q;
  logic [COUNT_BITS-1:0]      cnt_q;
  logic [DEPTH_W-1:0]         depth;
  logic [DEPTH_W-1:0]         depth_next;
  logic [DEPTH_W-1:0]         low_mark;
  logic [DEPTH_W-1:0]         low_mark_next;
  logic [IDX_W-1:0]           clr_idx;

  logic [PX_W-1:0]       in_page_x;
  logic [PX_W-1:0]       page_x;
  logic [PX_W-1:0]       top_x;
  logic [IDX_W-1:0]      page_idx;
  logic [DEPTH_W-1:0]    pop_idx;
  logic [IDX_W-1:0]      top;
  logic                  page_ok;

  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  push;

  logic [rpa_pkg::STATUS_W-1:0] res_status;
  logic [rpa_pkg::PAGE_W-1:0]   res_page;
  logic [COUNT_BITS-1:0]        res_count;
  logic                         res_released;
  logic [CX_W-1:0]              res_count_x;

  assign in_page_x = PX_W'(in_page);
  assign page_x    = PX_W'(page_q);
  assign page_idx  = page_x[IDX_W-1:0];
  assign page_ok   = (32'(page_q) < 32'(NUM_PAGES));
  assign pop_idx   = depth - DEPTH_W'(1);
  // entries below the lowest depth ever popped to were never written; each is read as its own index
  assign top       = (pop_idx < low_mark) ? pop_idx[IDX_W-1:0] : stack_q;
  assign top_x     = PX_W'(top);

  assign sts.clear_done = (clr_idx == IDX_LAST);
  assign sts.out_busy   = out_valid && !out_ready;

  always_comb begin
    res_status    = rpa_pkg::ST_OK;
    res_page      = page_q;
    res_count     = cnt_q;
    res_released  = 1'b0;
    cnt_we        = 1'b0;
    cnt_waddr     = page_idx;
    cnt_wdata     = cnt_q;
    push          = 1'b0;
    depth_next    = depth;
    low_mark_next = low_mark;
    if (op_q == rpa_pkg::OP_ALLOC) begin
      if (depth == '0) begin
        res_status = rpa_pkg::ST_OOM;
        res_page   = '0;
        res_count  = '0;
      end else begin
        res_page   = top_x[rpa_pkg::PAGE_W-1:0];
        res_count  = CNT_ONE;
        cnt_we     = 1'b1;
        cnt_waddr  = top;
        cnt_wdata  = CNT_ONE;
        depth_next = pop_idx;
        if (pop_idx < low_mark) begin
          low_mark_next = pop_idx;
        end
      end
    end else if (!page_ok) begin
      res_status = rpa_pkg::ST_BAD;
      res_count  = '0;
    end else begin
      case (op_q)
        rpa_pkg::OP_FREE: begin
          if (cnt_q == '0) begin
            res_status = rpa_pkg::ST_BAD;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_q - CNT_ONE;
            res_count = cnt_q - CNT_ONE;
            if (cnt_q == CNT_ONE) begin
              res_released = 1'b1;
              // a full stack drops the push
              if (depth < DEPTH_FULL) begin
                push       = 1'b1;
                depth_next = depth + DEPTH_W'(1);
              end
            end
          end
        end
        rpa_pkg::OP_ADDREF: begin
          cnt_we    = 1'b1;
          cnt_wdata = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_ONE;
          res_count = cnt_wdata;
        end
        default: begin
          res_count = cnt_q;
        end
      endcase
    end
  end

  assign res_count_x = CX_W'(res_count);

  // count memory: one write port shared by the reset sweep and execution
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      cnt_mem[clr_idx] <= '0;
    end else if (cmd.fire && cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cmd.load) begin
      cnt_q <= cnt_mem[in_page_x[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire && push) begin
      stack_mem[depth[IDX_W-1:0]] <= page_idx;
    end
    if (cmd.load) begin
      stack_q <= stack_mem[pop_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= in_op;
      page_q <= in_page;
    end
    if (cmd.fire) begin
      out_status   <= res_status;
      out_page     <= res_page;
      out_count    <= res_count_x[rpa_pkg::OCNT_W-1:0];
      out_released <= res_released;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= DEPTH_FULL;
      low_mark  <= DEPTH_FULL;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.fire) begin
        depth    <= depth_next;
        low_mark <= low_mark_next;
      end
      if (cmd.clear_en && !sts.clear_done) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      out_valid <= cmd.fire || (out_valid && !out_ready);
    end
  end

endmodule

// ----- rtl/refcounted_page_allocator_top.sv -----
// An input transfer latches op and page and starts the memory reads; no new input is taken until
// execution does the read-modify-write and loads the result register, later if the output stalls.
// The result register lets the next input transfer happen while a result waits.
// Reset: synchronous; the count memory is swept to zero entry by entry,
// no input is taken during the sweep. The free stack needs no sweep.
`timescale 1ns / 1ps

module refcounted_page_allocator_top #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rpa_pkg::IN_DATA_W-1:0]    s_tdata,   // op[1:0], page[16:2], zero pad
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rpa_pkg::OUT_DATA_W-1:0]   m_tdata    // status[1:0], result_page[16:2],
                                                      // new_count[24:17], released[25], pad
);

  rpa_pkg::cmd_t cmd;
  rpa_pkg::sts_t sts;

  logic [rpa_pkg::STATUS_W-1:0] out_status;
  logic [rpa_pkg::PAGE_W-1:0]   out_page;
  logic [rpa_pkg::OCNT_W-1:0]   out_count;
  logic                         out_released;

  rpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpa_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (s_tdata[1:0]),
    .in_page      (s_tdata[16:2]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_status   (out_status),
    .out_page     (out_page),
    .out_count    (out_count),
    .out_released (out_released)
  );

  assign m_tdata = {6'd0, out_released, out_count, out_page, out_status};

endmodule
